// File: hdl/acpsr_pkg.sv
// ----------------------------------------------------------------------------
// acpsr_pkg
// Shared constants, codes and control types for the CPSR / banked register
// block.
// ----------------------------------------------------------------------------
package acpsr_pkg;

    // Action codes carried in s_axis_tuser[2:0]
    localparam logic [2:0] ACT_WR_FULL  = 3'd0;
    localparam logic [2:0] ACT_WR_CTRL  = 3'd1;
    localparam logic [2:0] ACT_SET_NZCVQ = 3'd2;
    localparam logic [2:0] ACT_SET_NZCV = 3'd3;
    localparam logic [2:0] ACT_RD_CPSR  = 3'd4;
    localparam logic [2:0] ACT_WR_REG   = 3'd5;
    localparam logic [2:0] ACT_RD_REG   = 3'd6;

    // Visible register select codes
    localparam logic [1:0] SEL_SP   = 2'd0;
    localparam logic [1:0] SEL_LR   = 2'd1;
    localparam logic [1:0] SEL_PC   = 2'd2;
    localparam logic [1:0] SEL_SPSR = 2'd3;

    // ARM mode codes
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_UND = 5'h1B;

    // Bank slots
    localparam logic [1:0] SLOT_SVC = 2'd0;
    localparam logic [1:0] SLOT_ABT = 2'd1;
    localparam logic [1:0] SLOT_IRQ = 2'd2;
    localparam logic [1:0] SLOT_UND = 2'd3;
    localparam int         NUM_SLOTS = 4;

    // Status word layout
    localparam int          T_POS = 5;
    localparam int          I_POS = 7;
    localparam int          Q_POS = 27;
    localparam logic [31:0] LOW_MASK      = 32'h0FFF_FFFF;
    localparam logic [31:0] PC_ALIGN_MASK = 32'hFFFF_FFFE;
    localparam logic [27:0] STATUS_RESET  = 28'h000_00D3;

    typedef struct packed {
        logic       valid;
        logic [1:0] idx;
    } bank_slot_t;

    typedef struct packed {
        logic latch;   // capture the accepted item
        logic swap;    // exchange visible regs with the current mode's bank
        logic commit;  // execute the action
        logic push;    // move the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic mode_change; // pending status write changes the mode
        logic out_free;    // output register can take a result this cycle
    } dp_sts_t;

    function automatic bank_slot_t slot_of(logic [4:0] mode);
        bank_slot_t s;
        s.valid = 1'b1;
        s.idx   = SLOT_SVC;
        case (mode)
            MODE_SVC: s.idx = SLOT_SVC;
            MODE_ABT: s.idx = SLOT_ABT;
            MODE_IRQ: s.idx = SLOT_IRQ;
            MODE_UND: s.idx = SLOT_UND;
            default:  s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/acpsr_datapath.sv
// ----------------------------------------------------------------------------
// acpsr_datapath
// Visible registers, mode banks, CPSR state, action execution and the
// output register.
// ----------------------------------------------------------------------------
module acpsr_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic [31:0]        in_value,
    input  logic [2:0]         in_action,
    input  logic [1:0]         in_reg_sel,
    input  acpsr_pkg::dp_cmd_t cmd,
    output acpsr_pkg::dp_sts_t sts,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [31:0]        out_read_data,
    output logic               out_irq_changed
);

    logic        has_thumb_reg, has_thumb_next;
    logic [2:0]  act_reg, act_next;
    logic [31:0] value_reg, value_next;
    logic [1:0]  sel_reg, sel_next;

    logic [31:0] sp_reg, sp_next;
    logic [31:0] lr_reg, lr_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] spsr_reg, spsr_next;
    logic [31:0] bank_sp_reg   [acpsr_pkg::NUM_SLOTS];
    logic [31:0] bank_sp_next  [acpsr_pkg::NUM_SLOTS];
    logic [31:0] bank_lr_reg   [acpsr_pkg::NUM_SLOTS];
    logic [31:0] bank_lr_next  [acpsr_pkg::NUM_SLOTS];
    logic [31:0] bank_spsr_reg [acpsr_pkg::NUM_SLOTS];
    logic [31:0] bank_spsr_next[acpsr_pkg::NUM_SLOTS];
    logic [27:0] status_low_reg, status_low_next;
    logic [3:0]  flags_reg, flags_next;

    logic [31:0] res_data_reg, res_data_next;
    logic        res_irq_reg, res_irq_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_irq_reg, out_irq_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0]           word;
    logic                  is_status_wr;
    acpsr_pkg::bank_slot_t slot;

    // Status word as it would be written, T bit forced low without Thumb
    always_comb begin
        word = value_reg;
        if (act_reg == acpsr_pkg::ACT_WR_CTRL) begin
            word = value_reg & acpsr_pkg::LOW_MASK;
        end
        if (!has_thumb_reg) begin
            word[acpsr_pkg::T_POS] = 1'b0;
        end
    end

    assign is_status_wr = (act_reg == acpsr_pkg::ACT_WR_FULL) ||
                          (act_reg == acpsr_pkg::ACT_WR_CTRL);
    assign slot = acpsr_pkg::slot_of(status_low_reg[4:0]);

    assign sts.mode_change = is_status_wr && (status_low_reg[4:0] != word[4:0]);
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_comb begin
        has_thumb_next  = cfg_wr_en ? cfg_wr_data : has_thumb_reg;
        act_next        = act_reg;
        value_next      = value_reg;
        sel_next        = sel_reg;
        sp_next         = sp_reg;
        lr_next         = lr_reg;
        pc_next         = pc_reg;
        spsr_next       = spsr_reg;
        bank_sp_next    = bank_sp_reg;
        bank_lr_next    = bank_lr_reg;
        bank_spsr_next  = bank_spsr_reg;
        status_low_next = status_low_reg;
        flags_next      = flags_reg;
        res_data_next   = res_data_reg;
        res_irq_next    = res_irq_reg;
        out_data_next   = out_data_reg;
        out_irq_next    = out_irq_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.latch) begin
            act_next   = in_action;
            value_next = in_value;
            sel_next   = in_reg_sel;
        end

        // Unbanked modes leave everything alone
        if (cmd.swap && slot.valid) begin
            sp_next                  = bank_sp_reg[slot.idx];
            lr_next                  = bank_lr_reg[slot.idx];
            spsr_next                = bank_spsr_reg[slot.idx];
            bank_sp_next[slot.idx]   = sp_reg;
            bank_lr_next[slot.idx]   = lr_reg;
            bank_spsr_next[slot.idx] = spsr_reg;
        end

        if (cmd.commit) begin
            res_data_next = '0;
            res_irq_next  = 1'b0;
            case (act_reg)
                acpsr_pkg::ACT_WR_FULL, acpsr_pkg::ACT_WR_CTRL: begin
                    // ARM to Thumb entry realigns the PC
                    if (word[acpsr_pkg::T_POS] && !status_low_reg[acpsr_pkg::T_POS]) begin
                        pc_next = pc_reg & acpsr_pkg::PC_ALIGN_MASK;
                    end
                    res_irq_next    = status_low_reg[acpsr_pkg::I_POS] ^
                                      word[acpsr_pkg::I_POS];
                    status_low_next = word[27:0];
                    if (act_reg == acpsr_pkg::ACT_WR_FULL) begin
                        flags_next = word[31:28];
                    end
                end
                acpsr_pkg::ACT_SET_NZCVQ: begin
                    flags_next = value_reg[31:28];
                    status_low_next[acpsr_pkg::Q_POS] = value_reg[acpsr_pkg::Q_POS];
                end
                acpsr_pkg::ACT_SET_NZCV: begin
                    flags_next = value_reg[31:28];
                end
                acpsr_pkg::ACT_RD_CPSR: begin
                    res_data_next = {flags_reg, status_low_reg};
                end
                acpsr_pkg::ACT_WR_REG: begin
                    case (sel_reg)
                        acpsr_pkg::SEL_SP:   sp_next   = value_reg;
                        acpsr_pkg::SEL_LR:   lr_next   = value_reg;
                        acpsr_pkg::SEL_PC:   pc_next   = value_reg;
                        acpsr_pkg::SEL_SPSR: spsr_next = value_reg;
                        default:             spsr_next = value_reg;
                    endcase
                end
                acpsr_pkg::ACT_RD_REG: begin
                    case (sel_reg)
                        acpsr_pkg::SEL_SP:   res_data_next = sp_reg;
                        acpsr_pkg::SEL_LR:   res_data_next = lr_reg;
                        acpsr_pkg::SEL_PC:   res_data_next = pc_reg;
                        acpsr_pkg::SEL_SPSR: res_data_next = spsr_reg;
                        default:             res_data_next = spsr_reg;
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (cmd.push) begin
            out_data_next  = res_data_reg;
            out_irq_next   = res_irq_reg;
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_thumb_reg  <= 1'b1;
            sp_reg         <= '0;
            lr_reg         <= '0;
            pc_reg         <= '0;
            spsr_reg       <= '0;
            for (int i = 0; i < acpsr_pkg::NUM_SLOTS; i++) begin
                bank_sp_reg[i]   <= '0;
                bank_lr_reg[i]   <= '0;
                bank_spsr_reg[i] <= '0;
            end
            status_low_reg <= acpsr_pkg::STATUS_RESET;
            flags_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            has_thumb_reg  <= has_thumb_next;
            sp_reg         <= sp_next;
            lr_reg         <= lr_next;
            pc_reg         <= pc_next;
            spsr_reg       <= spsr_next;
            bank_sp_reg    <= bank_sp_next;
            bank_lr_reg    <= bank_lr_next;
            bank_spsr_reg  <= bank_spsr_next;
            status_low_reg <= status_low_next;
            flags_reg      <= flags_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        value_reg    <= value_next;
        sel_reg      <= sel_next;
        res_data_reg <= res_data_next;
        res_irq_reg  <= res_irq_next;
        out_data_reg <= out_data_next;
        out_irq_reg  <= out_irq_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_read_data   = out_data_reg;
    assign out_irq_changed = out_irq_reg;

    // Swap and commit are separate steps of a status write
    a_swap_commit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.swap && cmd.commit))
        else $error("swap and commit in the same cycle");

    // A result never overwrites one that is still waiting
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("push into a full output register");

endmodule

// File: hdl/acpsr_ctrl.sv
// ----------------------------------------------------------------------------
// acpsr_ctrl
// Sequencer for one item: check, optional bank swap out, commit, optional
// bank swap in, result hand-off.
// ----------------------------------------------------------------------------
module acpsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  acpsr_pkg::dp_sts_t sts,
    output acpsr_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CHECK    = 6'b000010,
        ST_SWAP_OUT = 6'b000100,
        ST_COMMIT   = 6'b001000,
        ST_SWAP_IN  = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.latch = in_valid;
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.mode_change ? ST_SWAP_OUT : ST_COMMIT;
            end
            ST_SWAP_OUT: begin
                cmd.swap   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // mode still reflects the old status here
                cmd.commit = 1'b1;
                state_next = sts.mode_change ? ST_SWAP_IN : ST_DONE;
            end
            ST_SWAP_IN: begin
                cmd.swap   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    a_swap_not_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |=> !cmd.swap)
        else $error("two bank swaps in a row");

    a_swap_out_needs_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP_OUT) |-> sts.mode_change)
        else $error("bank swap without a mode change");

    a_commit_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> ($past(state_reg) == ST_CHECK || $past(state_reg) == ST_SWAP_OUT))
        else $error("commit out of sequence");

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch |=> (state_reg == ST_CHECK))
        else $error("accepted item not checked");

endmodule

// File: hdl/arm_cpsr_banked_register_update.sv
// ----------------------------------------------------------------------------
// arm_cpsr_banked_register_update
// ARM v4 CPSR with mode-banked R13, R14 and SPSR, stream interface.
// ----------------------------------------------------------------------------
// One action per input transfer, one result transfer per action. An item is
// taken only while the sequencer is idle; it then passes a check step, a
// commit step and a hand-off step, plus one bank swap step before and one
// after the commit when a CPSR write changes the mode. The hand-off waits
// until the output register is free. The swaps share one exchange path
// between the visible registers and the bank of the current mode. The
// result sits in an output register, so a new item is taken while an
// earlier result still waits. has_thumb is written through cfg_wr_en /
// cfg_wr_data and resets to 1.
// ----------------------------------------------------------------------------
module arm_cpsr_banked_register_update (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // has_thumb
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] value
    input  logic [4:0]  s_axis_tuser,    // [2:0] action, [4:3] reg_sel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // [31:0] read_data, [32] irq_mask_changed
);

    acpsr_pkg::dp_cmd_t cmd;
    acpsr_pkg::dp_sts_t sts;
    logic [31:0]        read_data;
    logic               irq_changed;

    acpsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    acpsr_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_value        (s_axis_tdata),
        .in_action       (s_axis_tuser[2:0]),
        .in_reg_sel      (s_axis_tuser[4:3]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_read_data   (read_data),
        .out_irq_changed (irq_changed)
    );

    assign m_axis_tdata = {7'b0, irq_changed, read_data};

endmodule
